FILE: design/sequencer_loop_stack_core_macros.svh
// ----------------------------------------------------------------------------
// Sequencer loop stack assertion macros
// Shared concurrent assertion forms, clocked on clock and disabled in reset.
// ----------------------------------------------------------------------------
`ifndef SEQUENCER_LOOP_STACK_CORE_MACROS_SVH
`define SEQUENCER_LOOP_STACK_CORE_MACROS_SVH

// A condition that must hold at every clock edge outside reset.
`define SLSC_ASSERT_ALWAYS(label, expr) \
   label: assert property (@(posedge clock) disable iff (reset) (expr)) \
      else $error("sequencer loop stack check failed");

// A consequence that must hold in the same cycle as its cause.
`define SLSC_ASSERT_IMPLY(label, ante, cons) \
   label: assert property (@(posedge clock) disable iff (reset) (ante) |-> (cons)) \
      else $error("sequencer loop stack check failed");

// A consequence that must hold in the cycle after its cause.
`define SLSC_ASSERT_NEXT(label, ante, cons) \
   label: assert property (@(posedge clock) disable iff (reset) (ante) |=> (cons)) \
      else $error("sequencer loop stack check failed");

`endif

FILE: design/slsc_pkg.sv
// ----------------------------------------------------------------------------
// Sequencer loop stack package
// Command codes, transfer structs and constants shared by the loop stack core.
// ----------------------------------------------------------------------------
`default_nettype none

package slsc_pkg;

   localparam int ADDR_BITS_DEFAULT   = 16;
   localparam int STACK_DEPTH_DEFAULT = 4;

   localparam int COUNT_BITS = 16;

   // A count byte of zero stands for this many repeats.
   localparam logic [8:0] COUNT_ZERO_LIMIT = 9'h100;

   // Operand bytes skipped by the conditional jumps.
   localparam int OPERAND_SKIP = 3;

   typedef enum logic [2:0] {
      CMD_PUSH          = 3'd0,
      CMD_LOOP_COUNT    = 3'd1,
      CMD_JUMP_IF_COUNT = 3'd2,
      CMD_JUMP_POP      = 3'd3,
      CMD_RETURN        = 3'd4
   } slsc_cmd_type;

   typedef struct packed {
      logic [2:0]         cmd;
      logic [15:0]        cur_pc;
      logic [7:0]         count_byte;
      logic signed [15:0] jump_offset;
   } slsc_req_type;

   typedef struct packed {
      logic [15:0] next_pc;
      logic        count_reached;
   } slsc_rsp_type;

   // Write enables from the command logic to the stack storage.
   typedef struct packed {
      logic top_we;
      logic addr_we;
      logic cnt_we;
   } slsc_stk_we_type;

endpackage

`default_nettype wire

FILE: design/slsc_stack.sv
// ----------------------------------------------------------------------------
// Sequencer loop stack storage
// Ring of return addresses and repeat counters with a wrapping top pointer.
// ----------------------------------------------------------------------------
`default_nettype none

module slsc_stack #(
   parameter int ADDR_BITS   = 16,
   parameter int STACK_DEPTH = 4,
   parameter int SLOT_BITS   = 2
) (
   input  wire logic                          clock,
   input  wire logic                          reset,
   input  wire slsc_pkg::slsc_stk_we_type     we,
   input  wire logic [SLOT_BITS-1:0]          new_top,
   input  wire logic [SLOT_BITS-1:0]          wr_slot,
   input  wire logic [ADDR_BITS-1:0]          wr_addr,
   input  wire logic [slsc_pkg::COUNT_BITS-1:0] wr_count,
   output logic      [SLOT_BITS-1:0]          top_slot,
   output logic      [ADDR_BITS-1:0]          top_addr,
   output logic      [slsc_pkg::COUNT_BITS-1:0] top_count
);
   import slsc_pkg::*;

   logic [SLOT_BITS-1:0]  top_ff;
   logic [SLOT_BITS-1:0]  top_in;
   logic [ADDR_BITS-1:0]  addr_ff  [STACK_DEPTH];
   logic [ADDR_BITS-1:0]  addr_in  [STACK_DEPTH];
   logic [COUNT_BITS-1:0] count_ff [STACK_DEPTH];
   logic [COUNT_BITS-1:0] count_in [STACK_DEPTH];

   always_comb begin
      top_in = we.top_we ? new_top : top_ff;
      for (int i = 0; i < STACK_DEPTH; i++) begin
         addr_in[i]  = (we.addr_we && (wr_slot == SLOT_BITS'(i))) ? wr_addr  : addr_ff[i];
         count_in[i] = (we.cnt_we  && (wr_slot == SLOT_BITS'(i))) ? wr_count : count_ff[i];
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         top_ff <= '0;
         for (int i = 0; i < STACK_DEPTH; i++) begin
            addr_ff[i]  <= '0;
            count_ff[i] <= '0;
         end
      end else begin
         top_ff <= top_in;
         for (int i = 0; i < STACK_DEPTH; i++) begin
            addr_ff[i]  <= addr_in[i];
            count_ff[i] <= count_in[i];
         end
      end
   end

   assign top_slot  = top_ff;
   assign top_addr  = addr_ff[top_ff];
   assign top_count = count_ff[top_ff];

endmodule

`default_nettype wire

FILE: design/slsc_exec.sv
// ----------------------------------------------------------------------------
// Sequencer loop stack command logic
// Decodes one registered command against the stack top and forms the result.
// ----------------------------------------------------------------------------
`default_nettype none

module slsc_exec #(
   parameter int ADDR_BITS   = 16,
   parameter int STACK_DEPTH = 4,
   parameter int SLOT_BITS   = 2
) (
   input  wire logic                            valid,
   input  wire slsc_pkg::slsc_req_type          req,
   input  wire logic [SLOT_BITS-1:0]            top_slot,
   input  wire logic [ADDR_BITS-1:0]            top_addr,
   input  wire logic [slsc_pkg::COUNT_BITS-1:0] top_count,
   output slsc_pkg::slsc_rsp_type               rsp,
   output slsc_pkg::slsc_stk_we_type            we,
   output logic      [SLOT_BITS-1:0]            new_top,
   output logic      [SLOT_BITS-1:0]            wr_slot,
   output logic      [ADDR_BITS-1:0]            wr_addr,
   output logic      [slsc_pkg::COUNT_BITS-1:0] wr_count
);
   import slsc_pkg::*;

   localparam int WIDE_BITS = (ADDR_BITS > 16) ? ADDR_BITS : 16;

   logic [WIDE_BITS-1:0]  pc_wide;
   logic [WIDE_BITS-1:0]  off_wide;
   logic [WIDE_BITS-1:0]  next_wide;
   logic [ADDR_BITS-1:0]  pc_addr;
   logic [ADDR_BITS-1:0]  pc_plus1;
   logic [ADDR_BITS-1:0]  pc_plus3;
   logic [ADDR_BITS-1:0]  target;
   logic [ADDR_BITS-1:0]  next_addr;
   logic [8:0]            limit;
   logic [COUNT_BITS-1:0] count_inc;
   logic                  hit;
   logic [SLOT_BITS-1:0]  slot_next;
   logic [SLOT_BITS-1:0]  slot_prev;
   logic                  reached;

   always_comb begin
      pc_wide  = WIDE_BITS'(req.cur_pc);
      off_wide = WIDE_BITS'(req.jump_offset);
      pc_addr  = pc_wide[ADDR_BITS-1:0];
      pc_plus1 = pc_addr + ADDR_BITS'(1);
      pc_plus3 = pc_addr + ADDR_BITS'(OPERAND_SKIP);
      target   = pc_plus3 + off_wide[ADDR_BITS-1:0];

      limit     = (req.count_byte == 8'd0) ? COUNT_ZERO_LIMIT : {1'b0, req.count_byte};
      count_inc = top_count + COUNT_BITS'(1);
      // The incremented count never wraps onto a valid limit, so a 16-bit
      // compare serves both the wrapped and the unwrapped comparison.
      hit       = (count_inc == COUNT_BITS'(limit));

      slot_next = (top_slot == SLOT_BITS'(STACK_DEPTH - 1)) ? '0 : top_slot + SLOT_BITS'(1);
      slot_prev = (top_slot == '0) ? SLOT_BITS'(STACK_DEPTH - 1) : top_slot - SLOT_BITS'(1);

      we        = '0;
      new_top   = top_slot;
      wr_slot   = top_slot;
      wr_addr   = pc_addr;
      wr_count  = count_inc;
      next_addr = pc_addr;
      reached   = 1'b0;

      case (req.cmd)
         CMD_PUSH: begin
            we.top_we  = 1'b1;
            we.addr_we = 1'b1;
            we.cnt_we  = 1'b1;
            new_top    = slot_next;
            wr_slot    = slot_next;
            wr_count   = '0;
         end
         CMD_LOOP_COUNT: begin
            we.cnt_we = 1'b1;
            if (hit) begin
               we.top_we = 1'b1;
               new_top   = slot_prev;
               next_addr = pc_plus1;
               reached   = 1'b1;
            end else begin
               next_addr = top_addr;
            end
         end
         CMD_JUMP_IF_COUNT, CMD_JUMP_POP: begin
            if (hit) begin
               next_addr = target;
               reached   = 1'b1;
               if (req.cmd == CMD_JUMP_POP) begin
                  we.top_we = 1'b1;
                  new_top   = slot_prev;
               end
            end else begin
               next_addr = pc_plus3;
            end
         end
         CMD_RETURN: begin
            we.cnt_we = 1'b1;
            next_addr = top_addr;
         end
         default: begin
            next_addr = pc_addr;
         end
      endcase

      if (!valid) begin
         we = '0;
      end

      next_wide         = WIDE_BITS'(next_addr);
      rsp.next_pc       = next_wide[15:0];
      rsp.count_reached = reached;
   end

endmodule

`default_nettype wire

FILE: design/sequencer_loop_stack_core.sv
// ----------------------------------------------------------------------------
// Sequencer loop stack core
// Loop and return engine of a music-sequence bytecode interpreter.
// ----------------------------------------------------------------------------
// A command transfer is taken at a rising edge where start is high and busy
// is low. req_item carries the command, the address just after the opcode,
// the repeat count byte and the signed jump offset.
// Every command gives exactly one result transfer on rsp_item, marked by
// rsp_valid for one cycle. The receiver cannot stall, so results are never
// held back and nothing is buffered on the output side.
// A taken command passes the command register, executes against the stack and
// lands in the result register. Throughput is one command per clock while
// busy is low; the stack read-modify-write commits at the edge that captures
// the result, so back-to-back commands see each other's stack updates.
// Reset is synchronous and active high. It clears the top pointer, every
// return address and every repeat counter. busy is high during reset and
// for the first cycle after it, and low from then on.
// ----------------------------------------------------------------------------
`default_nettype none

`include "sequencer_loop_stack_core_macros.svh"

module sequencer_loop_stack_core #(
   parameter int ADDR_BITS   = slsc_pkg::ADDR_BITS_DEFAULT,
   parameter int STACK_DEPTH = slsc_pkg::STACK_DEPTH_DEFAULT
) (
   input  wire logic                   clock,
   input  wire logic                   reset,
   input  wire logic                   start,
   output logic                        busy,
   input  wire slsc_pkg::slsc_req_type req_item,
   output logic                        rsp_valid,
   output slsc_pkg::slsc_rsp_type      rsp_item
);
   import slsc_pkg::*;

   localparam int SLOT_BITS = (STACK_DEPTH > 1) ? $clog2(STACK_DEPTH) : 1;

   // Command register: holds the accepted transfer for the execute cycle.
   logic            req_valid_ff;
   logic            req_valid_in;
   slsc_req_type    req_ff;
   slsc_req_type    req_in;

   // Result register: drives the result ports for exactly one cycle.
   logic            rsp_valid_ff;
   logic            rsp_valid_in;
   slsc_rsp_type    rsp_ff;
   slsc_rsp_type    rsp_in;

   logic            busy_ff;
   logic            busy_in;

   slsc_stk_we_type                stk_we;
   logic [SLOT_BITS-1:0]           new_top;
   logic [SLOT_BITS-1:0]           wr_slot;
   logic [ADDR_BITS-1:0]           wr_addr;
   logic [COUNT_BITS-1:0]          wr_count;
   logic [SLOT_BITS-1:0]           top_slot;
   logic [ADDR_BITS-1:0]           top_addr;
   logic [COUNT_BITS-1:0]          top_count;

   always_comb begin
      busy_in      = 1'b0;
      req_valid_in = start && !busy_ff;
      req_in       = req_valid_in ? req_item : req_ff;
      // The result of the command in the execute cycle is captured at the
      // same edge that commits its stack update.
      rsp_valid_in = req_valid_ff;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff      <= 1'b1;
         req_valid_ff <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         busy_ff      <= busy_in;
         req_valid_ff <= req_valid_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      req_ff <= req_in;
      rsp_ff <= rsp_in;
   end

   slsc_exec #(
      .ADDR_BITS   (ADDR_BITS),
      .STACK_DEPTH (STACK_DEPTH),
      .SLOT_BITS   (SLOT_BITS)
   ) u_exec (
      .valid     (req_valid_ff),
      .req       (req_ff),
      .top_slot  (top_slot),
      .top_addr  (top_addr),
      .top_count (top_count),
      .rsp       (rsp_in),
      .we        (stk_we),
      .new_top   (new_top),
      .wr_slot   (wr_slot),
      .wr_addr   (wr_addr),
      .wr_count  (wr_count)
   );

   slsc_stack #(
      .ADDR_BITS   (ADDR_BITS),
      .STACK_DEPTH (STACK_DEPTH),
      .SLOT_BITS   (SLOT_BITS)
   ) u_stack (
      .clock     (clock),
      .reset     (reset),
      .we        (stk_we),
      .new_top   (new_top),
      .wr_slot   (wr_slot),
      .wr_addr   (wr_addr),
      .wr_count  (wr_count),
      .top_slot  (top_slot),
      .top_addr  (top_addr),
      .top_count (top_count)
   );

   assign busy      = busy_ff;
   assign rsp_valid = rsp_valid_ff;
   assign rsp_item  = rsp_ff;

   // Every accepted command yields exactly one result, through the command and result registers.
   `SLSC_ASSERT_ALWAYS(a_rsp_latency, rsp_valid == $past(start && !busy, 2))

   // The stack pointer moves only while a command is executing.
   `SLSC_ASSERT_NEXT(a_top_idle_hold, !req_valid_ff, $stable(top_slot))

   // Only the loop count and the conditional jumps can report a met count.
   `SLSC_ASSERT_IMPLY(a_reached_cmd, rsp_valid_ff && rsp_ff.count_reached, $past(req_ff.cmd) == CMD_LOOP_COUNT || $past(req_ff.cmd) == CMD_JUMP_IF_COUNT || $past(req_ff.cmd) == CMD_JUMP_POP)

endmodule

`default_nettype wire
